FILE: design/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, codes and constants for the character display write unit.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int MAX_DIGITS_DEF = 5;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_NUMBER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_CONV,
    S_SEND
  } state_t;

  localparam logic [1:0]  LINE_ONE     = 2'd1;
  localparam logic [1:0]  LINE_TWO     = 2'd2;
  localparam logic [7:0]  CMD_SET_ADDR = 8'h80;
  localparam logic [7:0]  LINE2_OFFSET = 8'h40;
  localparam logic [7:0]  CMD_FUNC_SET = 8'h38;
  localparam logic [7:0]  CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY    = 8'h06;
  localparam logic [7:0]  CMD_CLEAR    = 8'h01;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_MUL    = 16'hCCCD;
  localparam int          DIV10_SHIFT  = 19;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_conv;
    logic conv_last;
    logic none_left;
  } ctrl_stat_t;

  // init command picked by the number of writes still to go
  function automatic logic [7:0] init_cmd(input logic [2:0] left);
    logic [7:0] b;
    case (left)
      3'd4:    b = CMD_FUNC_SET;
      3'd3:    b = CMD_DISP_ON;
      3'd2:    b = CMD_ENTRY;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

FILE: design/char_lcd_command_and_number_writer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_command_and_number_writer_unit
// Turns one display operation into its command and data byte writes.
//
//   port group  dir  tdata                         tuser     tlast
//   s_axis      in   opcode, byte_value, line,     -         -
//                    column, number, digit_count
//   m_axis      out  bus_byte                      is_data   last write
//
// One operation at a time; s_axis_tready is high only while idle.
// Plain ops: an emit state loads the write register, then the send state
// presents each write and loads the next as it is taken. Show number: the
// divide-by-ten loop fills the digits before emit. Idle follows the last write.
// Output stalls hold the write register; no beat is lost or repeated.
// Reset (rst, synchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module char_lcd_command_and_number_writer_unit #(
  parameter int MAX_DIGITS = lcdw_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], byte_value[10:3], line[12:11], column[17:13],
  // number[33:18], digit_count[36:34], zero[39:37]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // is_data
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  lcdw_pkg::ctrl_cmd_t  cmd;
  lcdw_pkg::ctrl_stat_t stat;

  lcdw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcdw_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .in_data     (s_axis_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (m_axis_tdata),
    .out_is_data (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a write is pending");

  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("write presented straight after accept");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last write");

  a_more: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("run ended without last write");

endmodule

FILE: design/lcdw_ctrl.sv
// ----------------------------------------------------------------------------
// lcdw_ctrl
// Sequencer: capture, digit conversion, then one display write per beat.
// ----------------------------------------------------------------------------
module lcdw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lcdw_pkg::ctrl_stat_t stat,
  output lcdw_pkg::ctrl_cmd_t  cmd
);

  lcdw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcdw_pkg::S_IDLE: begin
        if (in_valid) state_next = lcdw_pkg::S_EMIT;
      end
      lcdw_pkg::S_EMIT: begin
        if (stat.need_conv)      state_next = lcdw_pkg::S_CONV;
        else if (stat.none_left) state_next = lcdw_pkg::S_IDLE;
        else                     state_next = lcdw_pkg::S_SEND;
      end
      lcdw_pkg::S_CONV: begin
        if (stat.conv_last) state_next = lcdw_pkg::S_EMIT;
      end
      lcdw_pkg::S_SEND: begin
        if (out_ready && stat.none_left) state_next = lcdw_pkg::S_IDLE;
      end
      default: state_next = lcdw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      lcdw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lcdw_pkg::S_EMIT: begin
        cmd.out_load = !stat.need_conv && !stat.none_left;
      end
      lcdw_pkg::S_CONV: begin
        cmd.conv_step = 1'b1;
      end
      lcdw_pkg::S_SEND: begin
        out_valid    = 1'b1;
        cmd.out_load = out_ready && !stat.none_left;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/lcdw_dp.sv
// ----------------------------------------------------------------------------
// lcdw_dp
// Operand registers, decimal digit extraction and output write register.
// ----------------------------------------------------------------------------
module lcdw_dp #(
  parameter int MAX_DIGITS = lcdw_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic [39:0]          in_data,
  input  lcdw_pkg::ctrl_cmd_t  cmd,
  output lcdw_pkg::ctrl_stat_t stat,
  output logic [7:0]           out_byte,
  output logic                 out_is_data,
  output logic                 out_last
);

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 5);

  lcdw_pkg::op_t   opcode;
  logic [7:0]      byte_value;
  logic [1:0]      line;
  logic [4:0]      column;
  logic [15:0]     work;
  logic [3:0]      digits [MAX_DIGITS];
  logic [IW-1:0]   dptr;
  logic [IW-1:0]   conv_cnt;
  logic [CW-1:0]   left;
  logic            cur_pend;
  logic            converted;

  // incoming fields
  logic [2:0]  in_opcode;
  logic [1:0]  in_line;
  logic [2:0]  in_count;
  logic        in_has_cur;
  logic [3:0]  nsat;
  logic [3:0]  writes;

  assign in_opcode  = in_data[2:0];
  assign in_line    = in_data[12:11];
  assign in_count   = in_data[36:34];
  assign in_has_cur = (in_line == lcdw_pkg::LINE_ONE) || (in_line == lcdw_pkg::LINE_TWO);
  assign nsat       = (4'(in_count) > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : 4'(in_count);

  always_comb begin
    case (in_opcode)
      lcdw_pkg::OP_INIT:   writes = 4'd4;
      lcdw_pkg::OP_CMD:    writes = 4'd1;
      lcdw_pkg::OP_DATA:   writes = 4'd1;
      lcdw_pkg::OP_CURSOR: writes = {3'b000, in_has_cur};
      lcdw_pkg::OP_NUMBER: writes = nsat + {3'b000, in_has_cur};
      default:             writes = 4'd0;
    endcase
  end

  // divide by ten through the reciprocal
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot10;
  logic [3:0]  rdig;

  assign prod   = 32'(work) * 32'(lcdw_pkg::DIV10_MUL);
  assign quot   = prod[31:lcdw_pkg::DIV10_SHIFT];
  assign quot10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign rdig   = 4'(work - quot10);

  // byte for the current write
  logic [7:0] addr;
  logic [7:0] cur_byte;
  logic       cur_data;

  always_comb begin
    addr = 8'(column) - 8'd1;
    if (line == lcdw_pkg::LINE_TWO) addr = addr + lcdw_pkg::LINE2_OFFSET;
    addr = addr | lcdw_pkg::CMD_SET_ADDR;
    cur_byte = 8'd0;
    cur_data = 1'b0;
    case (opcode)
      lcdw_pkg::OP_INIT:   cur_byte = lcdw_pkg::init_cmd(left[2:0]);
      lcdw_pkg::OP_CMD:    cur_byte = byte_value;
      lcdw_pkg::OP_DATA: begin
        cur_byte = byte_value;
        cur_data = 1'b1;
      end
      lcdw_pkg::OP_CURSOR: cur_byte = addr;
      lcdw_pkg::OP_NUMBER: begin
        if (cur_pend) begin
          cur_byte = addr;
        end else begin
          cur_byte = lcdw_pkg::ASCII_ZERO | {4'b0000, digits[dptr]};
          cur_data = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode     <= lcdw_pkg::op_t'(in_opcode);
      byte_value <= in_data[10:3];
      line       <= in_line;
      column     <= in_data[17:13];
      work       <= in_data[33:18];
      dptr       <= IW'(nsat - 4'd1);
      left       <= CW'(writes);
      cur_pend   <= in_has_cur;
      converted  <= 1'b0;
      conv_cnt   <= '0;
    end
    if (cmd.conv_step) begin
      work <= 16'(quot);
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digits[i] <= digits[i+1];
      end
      digits[MAX_DIGITS-1] <= rdig;
      conv_cnt <= conv_cnt + IW'(1);
      if (stat.conv_last) converted <= 1'b1;
    end
    if (cmd.out_load) begin
      out_byte    <= cur_byte;
      out_is_data <= cur_data;
      out_last    <= (left == CW'(1));
      left        <= left - CW'(1);
      if (opcode == lcdw_pkg::OP_NUMBER) begin
        if (cur_pend) cur_pend <= 1'b0;
        else          dptr     <= dptr - IW'(1);
      end
    end
  end

  assign stat.need_conv = (opcode == lcdw_pkg::OP_NUMBER) && !converted;
  assign stat.conv_last = (conv_cnt == IW'(MAX_DIGITS - 1));
  assign stat.none_left = (left == '0);

endmodule
